/* hdl/bel_pkg.sv */
// Shared types and codes for the box edge line intersection core.
// No dependencies; used by every module of the block.
package bel_pkg;

  // Query kinds
  localparam logic [1:0] OP_LINE    = 2'd0;
  localparam logic [1:0] OP_SEGMENT = 2'd1;
  localparam logic [1:0] OP_RAY     = 2'd2;

  // Edge codes, visited in this order
  localparam logic [1:0] EDGE_BOTTOM = 2'd0;
  localparam logic [1:0] EDGE_RIGHT  = 2'd1;
  localparam logic [1:0] EDGE_TOP    = 2'd2;
  localparam logic [1:0] EDGE_LEFT   = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_LOW_X  = 2'd0;
  localparam logic [1:0] REG_LOW_Y  = 2'd1;
  localparam logic [1:0] REG_HIGH_X = 2'd2;
  localparam logic [1:0] REG_HIGH_Y = 2'd3;

  // One edge test, prepared by the front end
  typedef struct packed {
    logic               skip;   // edge cannot hit, no arithmetic needed
    logic               final_edge;
    logic               horiz;
    logic [1:0]         edge_idx;
    logic signed [31:0] level;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    logic signed [31:0] pb;
    logic signed [31:0] db;
    logic signed [32:0] num;    // sign-normalized level minus origin
    logic [31:0]        den;    // magnitude of direction on crossing axis
  } job_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic [1:0]         edge_idx;
    logic               last;
  } result_t;

endpackage

/* hdl/bel_front.sv */
// Front end: box registers, query capture and per-edge job setup.
// Depends on bel_pkg.
module bel_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [1:0]            cfg_index_i,
  input  logic [31:0]           cfg_data_i,
  input  logic                  push,
  output logic                  full,
  input  logic [1:0]            operation_i,
  input  logic signed [31:0]    start_x_i,
  input  logic signed [31:0]    start_y_i,
  input  logic signed [31:0]    dir_x_i,
  input  logic signed [31:0]    dir_y_i,
  output logic                  job_push_o,
  input  logic                  job_full_i,
  output bel_pkg::job_t         job_o
);

  logic signed [31:0] low_x_q, low_y_q, high_x_q, high_y_q;
  logic               busy_q;
  logic [1:0]         cnt_q;
  logic [1:0]         op_q;
  logic signed [31:0] px_q, py_q, dx_q, dy_q;

  logic signed [31:0] lx, hx, ly, hy;
  logic               horiz;
  logic signed [31:0] pa, pb, da, db, level, lo, hi;
  logic signed [32:0] num_raw, num;
  logic [31:0]        den;
  logic               range_fail;

  assign cfg_ready_o = 1'b1;
  assign full        = busy_q;
  assign job_push_o  = busy_q && !job_full_i;

  // Write box corners
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_x_q  <= '0;
      low_y_q  <= '0;
      high_x_q <= 32'sd65536;
      high_y_q <= 32'sd65536;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        bel_pkg::REG_LOW_X:  low_x_q  <= cfg_data_i;
        bel_pkg::REG_LOW_Y:  low_y_q  <= cfg_data_i;
        bel_pkg::REG_HIGH_X: high_x_q <= cfg_data_i;
        bel_pkg::REG_HIGH_Y: high_y_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Capture a query, then issue one job per edge
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (!busy_q) begin
      if (push) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end
    end else if (job_push_o) begin
      cnt_q <= cnt_q + 2'd1;
      if (cnt_q == bel_pkg::EDGE_LEFT) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!busy_q && push) begin
      op_q <= operation_i;
      px_q <= start_x_i;
      py_q <= start_y_i;
      dx_q <= dir_x_i;
      dy_q <= dir_y_i;
    end
  end

  // Order corners and pick the edge geometry
  always_comb begin
    lx = (low_x_q < high_x_q) ? low_x_q : high_x_q;
    hx = (low_x_q < high_x_q) ? high_x_q : low_x_q;
    ly = (low_y_q < high_y_q) ? low_y_q : high_y_q;
    hy = (low_y_q < high_y_q) ? high_y_q : low_y_q;
    horiz = (cnt_q == bel_pkg::EDGE_BOTTOM) || (cnt_q == bel_pkg::EDGE_TOP);
    unique case (cnt_q)
      bel_pkg::EDGE_BOTTOM: level = ly;
      bel_pkg::EDGE_RIGHT:  level = hx;
      bel_pkg::EDGE_TOP:    level = hy;
      default:              level = lx;
    endcase
    pa = horiz ? py_q : px_q;
    pb = horiz ? px_q : py_q;
    da = horiz ? dy_q : dx_q;
    db = horiz ? dx_q : dy_q;
    lo = horiz ? lx : ly;
    hi = horiz ? hx : hy;
    // Normalize so the denominator is positive
    num_raw = {level[31], level} - {pa[31], pa};
    num     = da[31] ? -num_raw : num_raw;
    den     = da[31] ? (~da + 32'sd1) : da;
    case (op_q)
      bel_pkg::OP_SEGMENT: range_fail = num[32] || (num > $signed({1'b0, den}));
      bel_pkg::OP_RAY:     range_fail = num[32] || (num == '0);
      bel_pkg::OP_LINE:    range_fail = 1'b0;
      default:             range_fail = 1'b1;
    endcase
    job_o.skip       = (da == '0) || (hi == lo) || range_fail;
    job_o.final_edge = (cnt_q == bel_pkg::EDGE_LEFT);
    job_o.horiz      = horiz;
    job_o.edge_idx   = cnt_q;
    job_o.level      = level;
    job_o.lo         = lo;
    job_o.hi         = hi;
    job_o.pb         = pb;
    job_o.db         = db;
    job_o.num        = num;
    job_o.den        = den;
  end

endmodule

/* hdl/bel_jobq.sv */
// Two-entry queue of edge jobs between the front and back ends.
// Depends on bel_pkg.
module bel_jobq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  output logic          full_o,
  input  bel_pkg::job_t data_i,
  input  logic          pop_i,
  output logic          empty_o,
  output bel_pkg::job_t data_o
);

  bel_pkg::job_t mem_q [2];
  logic          wr_q, rd_q;
  logic [1:0]    cnt_q;

  assign full_o  = cnt_q[1];
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rd_q];

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

endmodule

/* hdl/bel_back.sv */
// Back end: products, range check, serial division, rounding, result queue.
// Depends on bel_pkg.
module bel_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                job_empty_i,
  output logic                job_pop_o,
  input  bel_pkg::job_t       job_i,
  output logic                empty,
  input  logic                pop,
  output logic                hit_o,
  output logic signed [31:0]  point_x_o,
  output logic signed [31:0]  point_y_o,
  output logic [1:0]          edge_index_o,
  output logic                last_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MA    = 4'd1;
  localparam logic [3:0] S_MB    = 4'd2;
  localparam logic [3:0] S_MC    = 4'd3;
  localparam logic [3:0] S_CK    = 4'd4;
  localparam logic [3:0] S_DIV   = 4'd5;
  localparam logic [3:0] S_RND   = 4'd6;
  localparam logic [3:0] S_FIN   = 4'd7;
  localparam logic [3:0] S_FLUSH = 4'd8;

  logic [3:0]          state_q, state_d;
  bel_pkg::job_t       job_q;
  logic signed [33:0]  mul_a, mul_b;
  logic signed [67:0]  prod_q, qq_q;
  logic [31:0]         rem_q, quo_q;
  logic [4:0]          div_cnt_q;
  logic                now_hit_q;
  bel_pkg::result_t    now_q, pend_q;
  logic                pend_v_q;

  logic [32:0]         trial;
  logic                up;
  logic signed [32:0]  v33;
  logic signed [31:0]  v;

  bel_pkg::result_t    oq_mem_q [2];
  logic                oq_wr_q, oq_rd_q;
  logic [1:0]          oq_cnt_q;
  logic                oq_push;
  bel_pkg::result_t    oq_data;
  bel_pkg::result_t    oq_head;

  assign job_pop_o = (state_q == S_IDLE) && !job_empty_i;

  // Select multiplier operands by step
  always_comb begin
    unique case (state_q)
      S_MA: begin
        mul_a = {{2{job_q.db[31]}}, job_q.db};
        mul_b = {job_q.num[32], job_q.num};
      end
      S_MB: begin
        mul_a = {{2{job_q.lo[31]}}, job_q.lo} - {{2{job_q.pb[31]}}, job_q.pb};
        mul_b = {2'b00, job_q.den};
      end
      default: begin
        mul_a = {{2{job_q.hi[31]}}, job_q.hi} - {{2{job_q.lo[31]}}, job_q.lo};
        mul_b = {2'b00, job_q.den};
      end
    endcase
  end

  // Division step, rounding and the along-edge coordinate
  always_comb begin
    trial = {rem_q, quo_q[31]} - {1'b0, job_q.den};
    up    = {rem_q, 1'b0} >= {1'b0, job_q.den};
    v33   = {job_q.lo[31], job_q.lo} + $signed({1'b0, quo_q}) + $signed({32'd0, up});
    v     = (v33 > $signed({job_q.hi[31], job_q.hi})) ? job_q.hi : v33[31:0];
  end

  // Decide what goes to the result queue
  always_comb begin
    oq_push = 1'b0;
    oq_data = pend_q;
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (!job_empty_i) state_d = job_i.skip ? S_FIN : S_MA;
      S_MA:    state_d = S_MB;
      S_MB:    state_d = S_MC;
      S_MC:    state_d = S_CK;
      S_CK:    state_d = (!qq_q[67] && (qq_q <= prod_q)) ? S_DIV : S_FIN;
      S_DIV:   if (div_cnt_q == 5'd31) state_d = S_RND;
      S_RND:   state_d = S_FIN;
      S_FIN: begin
        if (now_hit_q && pend_v_q) begin
          if (!oq_cnt_q[1]) begin
            oq_push      = 1'b1;
            oq_data.last = 1'b0;
            state_d      = job_q.final_edge ? S_FLUSH : S_IDLE;
          end
        end else begin
          state_d = job_q.final_edge ? S_FLUSH : S_IDLE;
        end
      end
      S_FLUSH: begin
        if (!oq_cnt_q[1]) begin
          oq_push = 1'b1;
          if (pend_v_q) begin
            oq_data.last = 1'b1;
          end else begin
            oq_data = '{hit: 1'b0, point_x: '0, point_y: '0, edge_idx: bel_pkg::EDGE_BOTTOM,
                        last: 1'b1};
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      pend_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_FIN && state_d != S_FIN && now_hit_q) pend_v_q <= 1'b1;
      if (state_q == S_FLUSH && oq_push) pend_v_q <= 1'b0;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    unique case (state_q)
      S_IDLE: begin
        job_q     <= job_i;
        now_hit_q <= 1'b0;
      end
      S_MB: qq_q <= prod_q;
      S_MC: qq_q <= qq_q - prod_q;
      S_CK: begin
        rem_q     <= qq_q[63:32];
        quo_q     <= qq_q[31:0];
        div_cnt_q <= '0;
      end
      S_DIV: begin
        div_cnt_q <= div_cnt_q + 5'd1;
        if (!trial[32]) begin
          rem_q <= trial[31:0];
          quo_q <= {quo_q[30:0], 1'b1};
        end else begin
          rem_q <= {rem_q[30:0], quo_q[31]};
          quo_q <= {quo_q[30:0], 1'b0};
        end
      end
      S_RND: begin
        now_hit_q        <= 1'b1;
        now_q.hit        <= 1'b1;
        now_q.point_x    <= job_q.horiz ? v : job_q.level;
        now_q.point_y    <= job_q.horiz ? job_q.level : v;
        now_q.edge_idx   <= job_q.edge_idx;
        now_q.last       <= 1'b0;
      end
      S_FIN: if (state_d != S_FIN && now_hit_q) pend_q <= now_q;
      default: ;
    endcase
  end

  // Result queue
  assign empty   = (oq_cnt_q == 2'd0);
  assign oq_head = oq_mem_q[oq_rd_q];
  assign hit_o        = oq_head.hit;
  assign point_x_o    = oq_head.point_x;
  assign point_y_o    = oq_head.point_y;
  assign edge_index_o = oq_head.edge_idx;
  assign last_o       = oq_head.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wr_q  <= 1'b0;
      oq_rd_q  <= 1'b0;
      oq_cnt_q <= '0;
    end else begin
      if (oq_push) oq_wr_q <= ~oq_wr_q;
      if (pop && !empty) oq_rd_q <= ~oq_rd_q;
      oq_cnt_q <= oq_cnt_q + {1'b0, oq_push} - {1'b0, pop && !empty};
    end
  end

  always_ff @(posedge clk_i) begin
    if (oq_push) oq_mem_q[oq_wr_q] <= oq_data;
  end

endmodule

/* hdl/box_edge_line_intersections_core.sv */
// Top level of the box edge line intersection core.
// Depends on bel_pkg, bel_front, bel_jobq and bel_back.
//
//   Channel  Handshake                 Payload
//   query    push / full               operation_i, start_x_i, start_y_i, dir_x_i, dir_y_i
//   result   empty / pop               hit_o, point_x_o, point_y_o, edge_index_o, last_o
//   config   cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// An edge that passes the front-end checks holds the back end through three multiplier
// passes, a range check, 32 divider steps and rounding; a skipped edge goes straight to
// the finish step, and a range miss stops after the range check.
// Reset clears all control state and loads the box corners to (0, 0) and (65536, 65536).
// A full result queue stalls the back end; the two-entry job queue then stalls the front.
module box_edge_line_intersections_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         operation_i,
  input  logic signed [31:0] start_x_i,
  input  logic signed [31:0] start_y_i,
  input  logic signed [31:0] dir_x_i,
  input  logic signed [31:0] dir_y_i,
  output logic               empty,
  input  logic               pop,
  output logic               hit_o,
  output logic signed [31:0] point_x_o,
  output logic signed [31:0] point_y_o,
  output logic [1:0]         edge_index_o,
  output logic               last_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  logic          jq_push, jq_full, jq_pop, jq_empty;
  bel_pkg::job_t jq_in, jq_out;

  bel_front u_front (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .push, .full, .operation_i, .start_x_i, .start_y_i, .dir_x_i, .dir_y_i,
    .job_push_o (jq_push), .job_full_i (jq_full), .job_o (jq_in)
  );

  bel_jobq u_jobq (
    .clk_i, .rst_ni,
    .push_i (jq_push), .full_o (jq_full), .data_i (jq_in),
    .pop_i (jq_pop), .empty_o (jq_empty), .data_o (jq_out)
  );

  bel_back u_back (
    .clk_i, .rst_ni,
    .job_empty_i (jq_empty), .job_pop_o (jq_pop), .job_i (jq_out),
    .empty, .pop, .hit_o, .point_x_o, .point_y_o, .edge_index_o, .last_o
  );

endmodule
